### rtl/core/cartridge_bank_controller_macros.svh
// assertion macros for the cartridge bank controller
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define CBC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cartridge bank controller check failed");

// next-cycle implication, checked on clock, off during reset
`define CBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cartridge bank controller check failed");

`endif

### rtl/core/cbc_pkg.sv
// shared types and constants of the cartridge bank controller
`timescale 1ns / 1ps
package cbc_pkg;

   localparam int EXTRAM_BYTES    = 32768;
   localparam int EXTRAM_AW       = $clog2(EXTRAM_BYTES);
   localparam int CLOCK_REG_COUNT = 5;
   localparam int CLOCK_IDX_W     = $clog2(CLOCK_REG_COUNT);

   localparam int BUS_ADDR_W  = 16;
   localparam int DATA_W      = 8;
   localparam int ROM_ADDR_W  = 23;
   localparam int ROM_SIZE_W  = 24;
   localparam int ROM_BANK_W  = 9;
   localparam int RAM_SEL_W   = 4;
   localparam int KIND_W      = 2;

   // access direction
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // configuration register indexes
   localparam logic CSR_KIND      = 1'b0;
   localparam logic CSR_ROM_BYTES = 1'b1;

   localparam logic [ROM_SIZE_W-1:0] ROM_BYTES_RESET = 24'h008000;

   // bank register data codes
   localparam logic [3:0]        RAM_ENABLE_CODE = 4'hA;
   localparam logic [DATA_W-1:0] LATCH_SET_CODE  = 8'h01;
   localparam logic [DATA_W-1:0] LATCH_CLR_CODE  = 8'h00;
   localparam logic [DATA_W-1:0] RAM_SEL_LO_MAX  = 8'h03;
   localparam logic [DATA_W-1:0] CLOCK_SEL_MIN   = 8'h08;
   localparam logic [DATA_W-1:0] CLOCK_SEL_MAX   = 8'h0C;
   localparam logic [DATA_W-1:0] OPEN_BUS        = 8'hFF;

   // register window inside 0x0000-0x7fff, from address bits 14:13
   localparam logic [1:0] WIN_RAM_ENABLE = 2'b00;
   localparam logic [1:0] WIN_ROM_BANK   = 2'b01;
   localparam logic [1:0] WIN_RAM_BANK   = 2'b10;
   localparam logic [1:0] WIN_LATCH      = 2'b11;

   // external ram window 0xa000-0xbfff, from address bits 15:13
   localparam logic [2:0] EXTRAM_REGION = 3'b101;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_MBC1 = 2'd1,
      KIND_MBC3 = 2'd2,
      KIND_MBC5 = 2'd3
   } kind_type;

   typedef struct packed {
      logic                  operation;
      logic [BUS_ADDR_W-1:0] bus_address;
      logic [DATA_W-1:0]     write_byte;
   } request_type;

   typedef struct packed {
      logic                  cart;
      logic                  fetch;
      logic [ROM_ADDR_W-1:0] phys;
      logic [DATA_W-1:0]     data;
      logic                  use_ram;
   } result_type;

   typedef struct packed {
      logic                 rd;
      logic                 wr;
      logic [EXTRAM_AW-1:0] addr;
      logic [DATA_W-1:0]    wdata;
   } ram_req_type;

endpackage

### rtl/core/cbc_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface cbc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [cbc_pkg::BUS_ADDR_W-1:0]  bus_address;
   logic [cbc_pkg::DATA_W-1:0]      write_byte;

   modport source (output valid, operation, bus_address, write_byte, input ready);
   modport sink   (input valid, operation, bus_address, write_byte, output ready);
endinterface

interface cbc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            in_cartridge;
   logic                            rom_fetch;
   logic [cbc_pkg::ROM_ADDR_W-1:0]  rom_byte_address;
   logic [cbc_pkg::DATA_W-1:0]      read_byte;

   modport source (output valid, in_cartridge, rom_fetch, rom_byte_address, read_byte,
                   input ready);
   modport sink   (input valid, in_cartridge, rom_fetch, rom_byte_address, read_byte,
                   output ready);
endinterface

### rtl/core/cbc_extram.sv
// external ram store with its clearing sweep after reset
`timescale 1ns / 1ps
module cbc_extram (
   input  logic                          clock,
   input  logic                          reset,
   input  cbc_pkg::ram_req_type          ram_req,
   output logic [cbc_pkg::DATA_W-1:0]    ram_rdata,
   output logic                          clear_busy
);

   logic [cbc_pkg::DATA_W-1:0]    mem [cbc_pkg::EXTRAM_BYTES];
   logic [cbc_pkg::DATA_W-1:0]    rdata_ff;
   logic [cbc_pkg::EXTRAM_AW-1:0] clr_addr_ff;
   logic [cbc_pkg::EXTRAM_AW-1:0] clr_addr_in;
   logic                          clr_busy_ff;
   logic                          clr_busy_in;
   logic                          clr_last;

   // sweep counter
   assign clr_last = (clr_addr_ff == cbc_pkg::EXTRAM_AW'(cbc_pkg::EXTRAM_BYTES - 1));

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_last) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // single port: sweep write, request write or registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (ram_req.wr) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end else if (ram_req.rd) begin
         rdata_ff <= mem[ram_req.addr];
      end
   end

   assign ram_rdata  = rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### rtl/core/cbc_bank_unit.sv
// bank registers, clock bytes and address decode for one request
`timescale 1ns / 1ps
module cbc_bank_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  cbc_pkg::request_type              req,
   input  cbc_pkg::kind_type                 kind,
   input  logic [cbc_pkg::ROM_SIZE_W-1:0]    rom_bytes,
   output cbc_pkg::result_type               res,
   output cbc_pkg::ram_req_type              ram_req
);

   logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [cbc_pkg::RAM_SEL_W-1:0]  ram_sel_ff, ram_sel_in;
   logic                           ram_en_ff, ram_en_in;
   logic                           latched_ff, latched_in;
   logic [cbc_pkg::DATA_W-1:0]     live_ff  [cbc_pkg::CLOCK_REG_COUNT];
   logic [cbc_pkg::DATA_W-1:0]     live_in  [cbc_pkg::CLOCK_REG_COUNT];
   logic [cbc_pkg::DATA_W-1:0]     latch_ff [cbc_pkg::CLOCK_REG_COUNT];
   logic [cbc_pkg::DATA_W-1:0]     latch_in [cbc_pkg::CLOCK_REG_COUNT];

   logic                           is_write;
   logic [cbc_pkg::DATA_W-1:0]     wbyte;
   logic [cbc_pkg::ROM_ADDR_W-1:0] rom_phys;
   logic [4:0]                     mbc1_low;
   logic [6:0]                     mbc3_bank;
   logic [cbc_pkg::CLOCK_IDX_W-1:0] clk_idx;
   logic [16:0]                    ram_off;

   assign is_write = (req.operation == cbc_pkg::OP_WRITE);
   assign wbyte    = req.write_byte;
   assign mbc1_low = (wbyte[4:0] == 5'd0) ? 5'd1 : wbyte[4:0];
   assign mbc3_bank = (wbyte[6:0] == 7'd0) ? 7'd1 : wbyte[6:0];
   assign clk_idx  = ram_sel_ff[cbc_pkg::CLOCK_IDX_W-1:0];
   assign ram_off  = {ram_sel_ff, req.bus_address[12:0]};

   // fixed bank below 0x4000, switchable bank above
   assign rom_phys = req.bus_address[14] ? {rom_bank_ff, req.bus_address[13:0]}
                                         : {9'd0, req.bus_address[13:0]};

   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_sel_in  = ram_sel_ff;
      ram_en_in   = ram_en_ff;
      latched_in  = latched_ff;
      live_in     = live_ff;
      latch_in    = latch_ff;
      res         = '0;
      ram_req     = '0;
      ram_req.wdata = wbyte;

      if (!req.bus_address[15]) begin
         // rom window: register writes or translated reads
         res.cart = 1'b1;
         if (is_write) begin
            if (step && kind != cbc_pkg::KIND_NONE) begin
               if (req.bus_address[14:13] == cbc_pkg::WIN_RAM_ENABLE) begin
                  ram_en_in = (wbyte[3:0] == cbc_pkg::RAM_ENABLE_CODE);
               end else begin
                  unique case (kind)
                     cbc_pkg::KIND_MBC1: begin
                        if (req.bus_address[14:13] == cbc_pkg::WIN_ROM_BANK) begin
                           rom_bank_in = {2'b00, rom_bank_ff[6:5], mbc1_low};
                        end else if (req.bus_address[14:13] == cbc_pkg::WIN_RAM_BANK) begin
                           rom_bank_in = {2'b00, wbyte[1:0], rom_bank_ff[4:0]};
                        end
                     end
                     cbc_pkg::KIND_MBC3: begin
                        if (req.bus_address[14:13] == cbc_pkg::WIN_ROM_BANK) begin
                           rom_bank_in = {2'b00, mbc3_bank};
                        end else if (req.bus_address[14:13] == cbc_pkg::WIN_RAM_BANK) begin
                           if (wbyte <= cbc_pkg::RAM_SEL_LO_MAX ||
                               (wbyte >= cbc_pkg::CLOCK_SEL_MIN &&
                                wbyte <= cbc_pkg::CLOCK_SEL_MAX)) begin
                              ram_sel_in = wbyte[3:0];
                           end
                        end else begin
                           if (wbyte == cbc_pkg::LATCH_SET_CODE && !latched_ff) begin
                              latch_in   = live_ff;
                              latched_in = 1'b1;
                           end else if (wbyte == cbc_pkg::LATCH_CLR_CODE) begin
                              latched_in = 1'b0;
                           end
                        end
                     end
                     cbc_pkg::KIND_MBC5: begin
                        if (req.bus_address[14:13] == cbc_pkg::WIN_ROM_BANK) begin
                           if (!req.bus_address[12]) begin
                              rom_bank_in = {rom_bank_ff[8], wbyte};
                           end else begin
                              rom_bank_in = {wbyte[0], rom_bank_ff[7:0]};
                           end
                        end else if (req.bus_address[14:13] == cbc_pkg::WIN_RAM_BANK) begin
                           ram_sel_in = wbyte[3:0];
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end else if ({1'b0, rom_phys} < rom_bytes) begin
            res.fetch = 1'b1;
            res.phys  = rom_phys;
         end else begin
            res.data = cbc_pkg::OPEN_BUS;
         end
      end else if (req.bus_address[15:13] == cbc_pkg::EXTRAM_REGION) begin
         // external ram window: ram store or clock bytes
         res.cart = 1'b1;
         if (!ram_en_ff) begin
            if (!is_write) begin
               res.data = cbc_pkg::OPEN_BUS;
            end
         end else if (kind == cbc_pkg::KIND_MBC3 && ram_sel_ff[3]) begin
            if (clk_idx < cbc_pkg::CLOCK_IDX_W'(cbc_pkg::CLOCK_REG_COUNT)) begin
               if (is_write) begin
                  if (step) begin
                     live_in[clk_idx] = wbyte;
                  end
               end else begin
                  res.data = latched_ff ? latch_ff[clk_idx] : live_ff[clk_idx];
               end
            end else if (!is_write) begin
               res.data = cbc_pkg::OPEN_BUS;
            end
         end else if ({1'b0, ram_off} < 18'(cbc_pkg::EXTRAM_BYTES)) begin
            ram_req.addr = ram_off[cbc_pkg::EXTRAM_AW-1:0];
            if (is_write) begin
               ram_req.wr = step;
            end else begin
               ram_req.rd  = step;
               res.use_ram = 1'b1;
            end
         end else if (!is_write) begin
            res.data = cbc_pkg::OPEN_BUS;
         end
      end else if (!is_write) begin
         res.data = cbc_pkg::OPEN_BUS;
      end
   end

   // bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff <= 9'd1;
         ram_sel_ff  <= '0;
         ram_en_ff   <= 1'b0;
         latched_ff  <= 1'b0;
         for (int i = 0; i < cbc_pkg::CLOCK_REG_COUNT; i++) begin
            live_ff[i]  <= '0;
            latch_ff[i] <= '0;
         end
      end else begin
         rom_bank_ff <= rom_bank_in;
         ram_sel_ff  <= ram_sel_in;
         ram_en_ff   <= ram_en_in;
         latched_ff  <= latched_in;
         live_ff     <= live_in;
         latch_ff    <= latch_in;
      end
   end

endmodule

### rtl/core/cartridge_bank_controller.sv
// Cartridge bank controller: an accepted request is registered in req_ff, decoded by
// the bank unit and the result registered in rsp_ff, which drives the response; decode
// waits while a held response is not taken. Throughput one request per cycle while
// responses are taken and no clear runs; bank state and the single ram port are used
// once per request, in order, so a read sees every earlier write. Reset (synchronous)
// restores bank registers and clears the 32768-byte external ram by a sweep of one
// byte per cycle, during which no request is accepted; configuration writes still land.
`timescale 1ns / 1ps
`include "cartridge_bank_controller_macros.svh"
module cartridge_bank_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [cbc_pkg::ROM_SIZE_W-1:0]    csr_write_data,
   cbc_req_if.sink                           req_bus,
   cbc_rsp_if.source                         rsp_bus
);

   cbc_pkg::kind_type             kind_ff;
   logic [cbc_pkg::ROM_SIZE_W-1:0] rom_bytes_ff;

   cbc_pkg::request_type          req_ff;
   logic                          s1_vld_ff, s1_vld_in;
   cbc_pkg::result_type           rsp_ff;
   logic                          s2_vld_ff, s2_vld_in;

   cbc_pkg::result_type           res;
   cbc_pkg::ram_req_type          ram_req;
   logic [cbc_pkg::DATA_W-1:0]    ram_rdata;
   logic                          clear_busy;
   logic                          s2_go;
   logic                          step;
   logic                          req_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= cbc_pkg::KIND_NONE;
         rom_bytes_ff <= cbc_pkg::ROM_BYTES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cbc_pkg::CSR_KIND:      kind_ff      <= cbc_pkg::kind_type'(
                                       csr_write_data[cbc_pkg::KIND_W-1:0]);
            cbc_pkg::CSR_ROM_BYTES: rom_bytes_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   assign s2_go         = !s2_vld_ff || rsp_bus.ready;
   assign step          = s1_vld_ff && s2_go;
   assign req_bus.ready = (!s1_vld_ff || step) && !clear_busy;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_vld_in     = req_take || (s1_vld_ff && !step);
   assign s2_vld_in     = step || (s2_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.operation   <= req_bus.operation;
         req_ff.bus_address <= req_bus.bus_address;
         req_ff.write_byte  <= req_bus.write_byte;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= res;
      end
   end

   cbc_bank_unit u_bank (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_ff),
      .kind      (kind_ff),
      .rom_bytes (rom_bytes_ff),
      .res       (res),
      .ram_req   (ram_req)
   );

   cbc_extram u_extram (
      .clock      (clock),
      .reset      (reset),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .clear_busy (clear_busy)
   );

   // response outputs
   assign rsp_bus.valid            = s2_vld_ff;
   assign rsp_bus.in_cartridge     = rsp_ff.cart;
   assign rsp_bus.rom_fetch        = rsp_ff.fetch;
   assign rsp_bus.rom_byte_address = rsp_ff.phys;
   assign rsp_bus.read_byte        = rsp_ff.use_ram ? ram_rdata : rsp_ff.data;

   // checks
   `CBC_ASSERT_IMPLY(a_no_request_while_clearing, clear_busy, !req_bus.ready)
   `CBC_ASSERT_NEXT(a_ram_read_lands, ram_req.rd, s2_vld_ff && rsp_ff.use_ram)
   `CBC_ASSERT_IMPLY(a_fetch_is_cart_read, s2_vld_ff && rsp_ff.fetch, rsp_ff.cart && !rsp_ff.use_ram)
   `CBC_ASSERT_IMPLY(a_fetch_has_no_data, s2_vld_ff && rsp_ff.fetch, rsp_ff.data == 8'h00)

endmodule
